// ===== hw/rtl/gdo_pkg.sv =====
// Shared types, constants and calendar helper functions for the date offset block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gdo_pkg;

  localparam int OFFSET_BITS_DEF = 20;
  localparam int DAY_W = 5;
  localparam int MON_W = 4;
  localparam int YEAR_W = 14;
  localparam int DAYS_W = 22;
  localparam int ALU_W_DEF = 25;

  localparam logic [MON_W-1:0] MONTHS = 4'd12;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [DAY_W-1:0] DAY_LAST = 5'd31;
  localparam logic [DAYS_W-1:0] DAYS_PAST_END = 22'd3652059;

  typedef enum logic [1:0] {
    CH_400,
    CH_100,
    CH_4,
    CH_1
  } chunk_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_YSTEP,
    OP_CLAMP,
    OP_SMON,
    OP_SDAY,
    OP_OFF,
    OP_CHK,
    OP_RSTEP,
    OP_RMON,
    OP_DONE
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Y400,
    ST_Y100,
    ST_Y4,
    ST_Y1,
    ST_CLAMP,
    ST_SMON,
    ST_SDAY,
    ST_OFF,
    ST_CHK,
    ST_R400,
    ST_R100,
    ST_R4,
    ST_R1,
    ST_RMON,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t    op;
    chunk_t chunk;
    logic   busy;
    logic   done;
  } ctl_t;

  typedef struct packed {
    logic step_ok;
    logic neg;
    logic high;
  } stat_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [DAYS_W-1:0] chunk_days(input chunk_t ch);
    logic [DAYS_W-1:0] d;
    case (ch)
      CH_400:  d = 22'd146097;
      CH_100:  d = 22'd36524;
      CH_4:    d = 22'd1461;
      default: d = 22'd365;
    endcase
    return d;
  endfunction

  function automatic logic [YEAR_W-1:0] chunk_years(input chunk_t ch);
    logic [YEAR_W-1:0] y;
    case (ch)
      CH_400:  y = 14'd400;
      CH_100:  y = 14'd100;
      CH_4:    y = 14'd4;
      default: y = 14'd1;
    endcase
    return y;
  endfunction

endpackage

// ===== hw/rtl/gdo_alu.sv =====
// Shared add/subtract unit of the date offset block; one operation per cycle.
// Depends on gdo_pkg for the default width.
`timescale 1ns / 1ps

module gdo_alu
  import gdo_pkg::*;
#(
  parameter int W = ALU_W_DEF
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] y,
  output logic         nonneg
);

  assign y = a + (sub ? ~b : b) + {{(W-1){1'b0}}, sub};
  assign nonneg = ~y[W-1];

endmodule

// ===== hw/rtl/gdo_ctrl.sv =====
// Sequencer of the date offset block: steps through year chunks and months.
// Depends on gdo_pkg for the state, operation and status types.
`timescale 1ns / 1ps

module gdo_ctrl
  import gdo_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_stall,
  input  stat_t st,
  output ctl_t  ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_Y400;
      ST_Y400:  if (!st.step_ok) state_next = ST_Y100;
      ST_Y100:  if (!st.step_ok) state_next = ST_Y4;
      ST_Y4:    if (!st.step_ok) state_next = ST_Y1;
      ST_Y1:    if (!st.step_ok) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_SMON;
      ST_SMON:  if (!st.step_ok) state_next = ST_SDAY;
      ST_SDAY:  state_next = ST_OFF;
      ST_OFF:   state_next = ST_CHK;
      ST_CHK:   state_next = (st.neg || st.high) ? ST_DONE : ST_R400;
      ST_R400:  if (!st.step_ok) state_next = ST_R100;
      ST_R100:  if (!st.step_ok) state_next = ST_R4;
      ST_R4:    if (!st.step_ok) state_next = ST_R1;
      ST_R1:    if (!st.step_ok) state_next = ST_RMON;
      ST_RMON:  if (!st.step_ok) state_next = ST_DONE;
      ST_DONE:  if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op    = OP_IDLE;
    ctl.chunk = CH_400;
    ctl.busy  = 1'b1;
    ctl.done  = 1'b0;
    case (state)
      ST_IDLE:  ctl.busy = 1'b0;
      ST_Y400:  ctl.op = OP_YSTEP;
      ST_Y100:  begin
        ctl.op    = OP_YSTEP;
        ctl.chunk = CH_100;
      end
      ST_Y4:    begin
        ctl.op    = OP_YSTEP;
        ctl.chunk = CH_4;
      end
      ST_Y1:    begin
        ctl.op    = OP_YSTEP;
        ctl.chunk = CH_1;
      end
      ST_CLAMP: ctl.op = OP_CLAMP;
      ST_SMON:  ctl.op = OP_SMON;
      ST_SDAY:  ctl.op = OP_SDAY;
      ST_OFF:   ctl.op = OP_OFF;
      ST_CHK:   ctl.op = OP_CHK;
      ST_R400:  ctl.op = OP_RSTEP;
      ST_R100:  begin
        ctl.op    = OP_RSTEP;
        ctl.chunk = CH_100;
      end
      ST_R4:    begin
        ctl.op    = OP_RSTEP;
        ctl.chunk = CH_4;
      end
      ST_R1:    begin
        ctl.op    = OP_RSTEP;
        ctl.chunk = CH_1;
      end
      ST_RMON:  ctl.op = OP_RMON;
      ST_DONE:  begin
        ctl.op   = OP_DONE;
        ctl.done = 1'b1;
      end
      default:  ctl.busy = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/gregorian_date_offset.sv =====
// Top level of the Gregorian date offset block: datapath registers and handshakes.
// Depends on gdo_pkg, gdo_alu and gdo_ctrl.
`timescale 1ns / 1ps

// Adds a signed day offset to a Gregorian date and returns the new date.
// Input channel: in_valid/in_stall with start_day, start_month, start_year and
// day_offset; a transfer happens when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with result_day, result_month,
// result_year and out_of_range; the result stays put while out_stall is high.
// One item is processed at a time; in_stall is high from the transfer until
// the result has been taken. The start date is turned into a day count by
// stepping through 400, 100, 4 and 1 year chunks and then months, the offset
// is added, and the count is taken apart the same way. Every step is one pass
// through the shared adder, so the time from input transfer to result valid
// depends on the year and month of the start date and of the result; the next
// input transfer can come in the cycle after the result transfer. A result
// that falls outside years 1 to 9999 is saturated to the first or last day
// and flagged with out_of_range.
// Reset returns the sequencer to idle and drops out_valid; no clearing pass
// is needed. While the receiver stalls, the block simply holds its result.
module gregorian_date_offset
  import gdo_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [DAY_W-1:0]              start_day,
  input  logic [MON_W-1:0]              start_month,
  input  logic [YEAR_W-1:0]             start_year,
  input  logic signed [OFFSET_BITS-1:0] day_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [DAY_W-1:0]              result_day,
  output logic [MON_W-1:0]              result_month,
  output logic [YEAR_W-1:0]             result_year,
  output logic                          out_of_range
);

  // Room for the day count plus any offset, and for the range compare.
  localparam int MAG_W = (OFFSET_BITS - 1 > DAYS_W) ? OFFSET_BITS - 1 : DAYS_W;
  localparam int ACC_W = MAG_W + 3;

  ctl_t  ctl;
  stat_t st;

  logic [ACC_W-1:0]       acc;
  logic [OFFSET_BITS-1:0] off_r;
  logic [YEAR_W-1:0]      yr;
  logic [MON_W-1:0]       mon;
  logic [MON_W-1:0]       kmon;
  logic [DAY_W-1:0]       day;
  logic [1:0]             cnt100;
  logic [4:0]             cnt4;
  logic [1:0]             cnt1;
  logic                   flag;

  logic [MON_W-1:0]  m_cl;
  logic [YEAR_W-1:0] y_cl;
  logic              leap;
  logic [DAY_W-1:0]  len_cur;
  logic [DAY_W-1:0]  len_k;
  logic [DAYS_W-1:0] kdays;
  logic [YEAR_W-1:0] kyears;
  logic [ACC_W-1:0]  opnd;
  logic              alu_sub;
  logic [ACC_W-1:0]  alu_y;
  logic              alu_nonneg;
  logic              cap_ok;
  logic              accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = ctl.busy;
  assign out_valid = ctl.done;

  assign result_day   = day;
  assign result_month = mon;
  assign result_year  = yr;
  assign out_of_range = flag;

  assign m_cl = (start_month == '0) ? 4'd1 : ((start_month > MONTHS) ? MONTHS : start_month);
  assign y_cl = (start_year == '0) ? 14'd1 : ((start_year > YEAR_MAX) ? YEAR_MAX : start_year);

  // The chunk counters hold the year as 400a + 100b + 4c + q + 1, so the
  // leap rule reduces to checks on the last three counts.
  assign leap = (cnt1 == 2'd3) && ((cnt4 != 5'd24) || (cnt100 == 2'd3));

  assign len_cur = month_len(mon, leap);
  assign len_k   = month_len(kmon, leap);
  assign kdays   = chunk_days(ctl.chunk);
  assign kyears  = chunk_years(ctl.chunk);

  always_comb begin
    opnd    = '0;
    alu_sub = 1'b0;
    case (ctl.op)
      OP_YSTEP: opnd = {{(ACC_W-DAYS_W){1'b0}}, kdays};
      OP_SMON:  opnd = {{(ACC_W-DAY_W){1'b0}}, len_k};
      OP_SDAY:  opnd = {{(ACC_W-DAY_W){1'b0}}, day - 5'd1};
      OP_OFF:   opnd = {{(ACC_W-OFFSET_BITS){off_r[OFFSET_BITS-1]}}, off_r};
      OP_CHK:   begin
        opnd    = {{(ACC_W-DAYS_W){1'b0}}, DAYS_PAST_END};
        alu_sub = 1'b1;
      end
      OP_RSTEP: begin
        opnd    = {{(ACC_W-DAYS_W){1'b0}}, kdays};
        alu_sub = 1'b1;
      end
      OP_RMON:  begin
        opnd    = {{(ACC_W-DAY_W){1'b0}}, len_cur};
        alu_sub = 1'b1;
      end
      default:  opnd = '0;
    endcase
  end

  gdo_alu #(
    .W(ACC_W)
  ) u_alu (
    .a      (acc),
    .b      (opnd),
    .sub    (alu_sub),
    .y      (alu_y),
    .nonneg (alu_nonneg)
  );

  // A 400-year remainder holds at most three full 100-year chunks, and a
  // 4-year remainder at most three full years.
  always_comb begin
    case (ctl.chunk)
      CH_100:  cap_ok = (cnt100 != 2'd3);
      CH_1:    cap_ok = (cnt1 != 2'd3);
      default: cap_ok = 1'b1;
    endcase
  end

  always_comb begin
    case (ctl.op)
      OP_YSTEP: st.step_ok = (yr >= kyears);
      OP_SMON:  st.step_ok = (kmon < mon);
      OP_RSTEP: st.step_ok = alu_nonneg && cap_ok;
      OP_RMON:  st.step_ok = (mon != MONTHS) && alu_nonneg;
      default:  st.step_ok = 1'b0;
    endcase
    st.neg  = acc[ACC_W-1];
    st.high = alu_nonneg;
  end

  gdo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .st        (st),
    .ctl       (ctl)
  );

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_IDLE: begin
        if (accept) begin
          acc    <= '0;
          off_r  <= day_offset;
          day    <= start_day;
          mon    <= m_cl;
          yr     <= y_cl - 14'd1;
          kmon   <= 4'd1;
          cnt100 <= '0;
          cnt4   <= '0;
          cnt1   <= '0;
          flag   <= 1'b0;
        end
      end
      OP_YSTEP: begin
        if (st.step_ok) begin
          yr  <= yr - kyears;
          acc <= alu_y;
          case (ctl.chunk)
            CH_100:  cnt100 <= cnt100 + 2'd1;
            CH_4:    cnt4 <= cnt4 + 5'd1;
            CH_1:    cnt1 <= cnt1 + 2'd1;
            default: cnt100 <= cnt100;
          endcase
        end
      end
      OP_CLAMP: begin
        if (day == '0) begin
          day <= 5'd1;
        end else if (day > len_cur) begin
          day <= len_cur;
        end
      end
      OP_SMON: begin
        if (st.step_ok) begin
          acc  <= alu_y;
          kmon <= kmon + 4'd1;
        end
      end
      OP_SDAY, OP_OFF: begin
        acc <= alu_y;
      end
      OP_CHK: begin
        if (st.neg) begin
          day  <= 5'd1;
          mon  <= 4'd1;
          yr   <= 14'd1;
          flag <= 1'b1;
        end else if (st.high) begin
          day  <= DAY_LAST;
          mon  <= MONTHS;
          yr   <= YEAR_MAX;
          flag <= 1'b1;
        end else begin
          yr     <= 14'd1;
          mon    <= 4'd1;
          cnt100 <= '0;
          cnt4   <= '0;
          cnt1   <= '0;
        end
      end
      OP_RSTEP: begin
        if (st.step_ok) begin
          yr  <= yr + kyears;
          acc <= alu_y;
          case (ctl.chunk)
            CH_100:  cnt100 <= cnt100 + 2'd1;
            CH_4:    cnt4 <= cnt4 + 5'd1;
            CH_1:    cnt1 <= cnt1 + 2'd1;
            default: cnt100 <= cnt100;
          endcase
        end
      end
      OP_RMON: begin
        if (st.step_ok) begin
          acc <= alu_y;
          mon <= mon + 4'd1;
        end else begin
          day <= acc[DAY_W-1:0] + 5'd1;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule
